[hw/rtl/csr_pkg.sv]
`default_nettype none
package csr_pkg;

    // register indexes on the configuration channel
    localparam logic [1:0] REG_CAMERA_X      = 2'd0;
    localparam logic [1:0] REG_CAMERA_Y      = 2'd1;
    localparam logic [1:0] REG_CAMERA_FACING = 2'd2;

    // angle constants, half turn is 128 units
    localparam logic [7:0]  HALF_TURN    = 8'd128;
    localparam logic [7:0]  QUARTER_TURN = 8'd64;
    localparam logic [14:0] BHASKARA_DEN = 15'd20480;

    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned QUOT_BITS = 16;

    // lane order: sin(dx), cos(dx), sin(dy), cos(dy)
    localparam int unsigned LANE_SX = 0;
    localparam int unsigned LANE_CX = 1;
    localparam int unsigned LANE_SY = 2;
    localparam int unsigned LANE_CY = 3;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic [7:0]         point_colour;
    } t_point;

    typedef struct packed {
        logic signed [15:0] cam_c;
        logic signed [15:0] cam_d;
        logic [7:0]         out_colour;
    } t_result;

    // one division lane: partial remainder, dividend low bits turning into quotient
    typedef struct packed {
        logic [14:0] rem;
        logic [15:0] low;
        logic        sgn;
    } t_lane;

    typedef struct packed {
        logic                       valid;
        logic [7:0]                 colour;
        logic [14:0]                div_s;
        logic [14:0]                div_c;
        t_lane [NUM_LANES-1:0]      lane;
    } t_cell;

endpackage
`default_nettype wire

[hw/rtl/csr_cell.sv]
`default_nettype none
module csr_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire csr_pkg::t_cell i_cell,
    output csr_pkg::t_cell     o_cell
);
    import csr_pkg::*;

    t_cell r_cell;
    t_cell n_cell;

    // one restoring division step on every lane
    always_comb begin
        logic [15:0] trial;
        logic [15:0] dv;
        logic        take;
        n_cell = i_cell;
        for (int i = 0; i < NUM_LANES; i++) begin
            dv    = (i == LANE_SX || i == LANE_SY) ? {1'b0, i_cell.div_s}
                                                   : {1'b0, i_cell.div_c};
            trial = {i_cell.lane[i].rem, i_cell.lane[i].low[15]};
            take  = (trial >= dv);
            n_cell.lane[i].rem = take ? 15'(trial - dv) : trial[14:0];
            n_cell.lane[i].low = {i_cell.lane[i].low[14:0], take};
        end
    end

    // payload moves every cycle, valid resets
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end
    end

    assign o_cell = r_cell;

endmodule
`default_nettype wire

[hw/rtl/camera_space_rotate.sv]
// camera_space_rotate: world point to camera space with a Bhaskara sine rotation
//
// config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 camera x, 1 camera y, 2 facing (low 8 bits); index 3 is ignored.
// o_cfg_ready is always high. Write only while no point is in flight.
//
// input: a point beat is taken at each edge with start high and busy low.
// busy never rises, so one point is taken every cycle.
// output: o_done strobes for one cycle with o_result; a beat passes these
// registers in order: offsets and angle terms, the multiply, the chain of
// QUOT_BITS division cells (one quotient bit each, all four sine/cosine
// terms side by side), then sign and sums.
// throughput is one point per cycle at any fill of the chain.
// reset (i_rst_n low, synchronous) zeroes config and valid registers and
// drops every beat in flight. the receiver cannot stall: results are not held.
`default_nettype none
module camera_space_rotate (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire csr_pkg::t_point i_point,
    output logic                 o_done,
    output csr_pkg::t_result     o_result,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [15:0]     i_cfg_data
);
    import csr_pkg::*;

    logic [15:0] r_cam_x;
    logic [15:0] r_cam_y;
    logic [7:0]  r_facing;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x  <= '0;
            r_cam_y  <= '0;
            r_facing <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CAMERA_X:      r_cam_x  <= i_cfg_data;
                REG_CAMERA_Y:      r_cam_y  <= i_cfg_data;
                REG_CAMERA_FACING: r_facing <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // stage a: offsets and angle products
    logic        r_a_valid;
    logic [7:0]  r_a_colour;
    logic [15:0] r_a_dx, r_a_dy;
    logic [12:0] r_a_prod_s, r_a_prod_c;
    logic        r_a_neg_s, r_a_neg_c;

    logic [7:0]  ang_s, ang_c, red_s, red_c;
    logic        neg_s, neg_c;
    logic [15:0] prod_s, prod_c;

    always_comb begin
        ang_s  = 8'(8'd0 - r_facing);
        ang_c  = 8'(ang_s + QUARTER_TURN);
        neg_s  = ang_s > HALF_TURN;
        neg_c  = ang_c > HALF_TURN;
        red_s  = neg_s ? 8'(ang_s - HALF_TURN) : ang_s;
        red_c  = neg_c ? 8'(ang_c - HALF_TURN) : ang_c;
        prod_s = red_s * 8'(HALF_TURN - red_s);
        prod_c = red_c * 8'(HALF_TURN - red_c);
    end

    always_ff @(posedge i_clk) begin
        r_a_colour <= i_point.point_colour;
        r_a_dx     <= 16'(i_point.point_x - r_cam_x);
        r_a_dy     <= 16'(i_point.point_y - r_cam_y);
        r_a_prod_s <= prod_s[12:0];
        r_a_prod_c <= prod_c[12:0];
        r_a_neg_s  <= neg_s;
        r_a_neg_c  <= neg_c;
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start;
        end
    end

    // stage b: magnitude times product, split into remainder and low bits
    t_cell chain [QUOT_BITS+1];
    t_cell n_b;
    t_cell r_b;

    always_comb begin
        logic [15:0] n_val;
        logic [15:0] mag;
        logic [12:0] prod;
        logic        ng;
        logic [27:0] mul;
        logic [29:0] dvd;
        n_b.valid  = r_a_valid;
        n_b.colour = r_a_colour;
        n_b.div_s  = 15'(BHASKARA_DEN - {2'b0, r_a_prod_s});
        n_b.div_c  = 15'(BHASKARA_DEN - {2'b0, r_a_prod_c});
        for (int i = 0; i < NUM_LANES; i++) begin
            n_val = (i == LANE_SX || i == LANE_CX) ? r_a_dx : r_a_dy;
            prod  = (i == LANE_SX || i == LANE_SY) ? r_a_prod_s : r_a_prod_c;
            ng    = (i == LANE_SX || i == LANE_SY) ? r_a_neg_s : r_a_neg_c;
            mag   = n_val[15] ? 16'(16'd0 - n_val) : n_val;
            mul   = mag * prod;
            dvd   = {mul, 2'b00};
            n_b.lane[i].rem = {1'b0, dvd[29:16]};
            n_b.lane[i].low = dvd[15:0];
            n_b.lane[i].sgn = n_val[15] ^ ng;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b <= n_b;
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end
    end

    assign chain[0] = r_b;

    // division chain, one quotient bit per cell
    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_cell
        csr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (chain[k]),
            .o_cell  (chain[k+1])
        );
    end

    // output stage: apply signs, form both coordinates
    t_cell       last;
    logic [15:0] term [NUM_LANES];
    logic        r_done;
    t_result     r_result;

    assign last = chain[QUOT_BITS];

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            term[i] = last.lane[i].sgn ? 16'(16'd0 - last.lane[i].low) : last.lane[i].low;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.cam_c      <= 16'(term[LANE_CX] - term[LANE_SY]);
        r_result.cam_d      <= 16'(term[LANE_SX] + term[LANE_CY]);
        r_result.out_colour <= last.colour;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= last.valid;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire

[hw/rtl/csr_checker.sv]
`default_nettype none
module csr_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_done,
    input wire csr_pkg::t_point  i_point,
    input wire csr_pkg::t_result o_result,
    input wire logic             o_cfg_ready
);
    localparam int unsigned LATENCY = 19;

    // every accepted beat gives a strobe after the fixed latency
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("result strobe missing");

    // no strobe without an accepted beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LATENCY !o_done)
        else $error("result strobe without input");

    // colour travels with its point
    a_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY
            (o_result.out_colour == $past(i_point.point_colour, LATENCY)))
        else $error("colour mismatch");

    // input and config channels never stall
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("channel stalled");

endmodule

bind camera_space_rotate csr_checker u_csr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .i_point     (i_point),
    .o_result    (o_result),
    .o_cfg_ready (o_cfg_ready)
);
`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csr_pkg::*;

    localparam int LATENCY     = 19;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_point      i_point = '0;
    logic        o_done;
    t_result     o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    camera_space_rotate u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_point(i_point), .o_done(o_done), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // local copy of the camera registers
    logic signed [15:0] cam_x_q = '0;
    logic signed [15:0] cam_y_q = '0;
    logic [7:0]         cam_facing_q = '0;

    t_result pending_results[$];
    int      errors = 0;
    int      cycles = 0;

    // bhaskara sine term at 16 bits
    function automatic logic signed [15:0] bhaskara_sin(input logic signed [15:0] n,
                                                         input logic [7:0] ang);
        int a, prod, q;
        logic neg;
        a = ang;
        neg = 1'b0;
        if (a > 128) begin
            a = a - 128;
            neg = 1'b1;
        end
        prod = a * (128 - a);
        q = (int'(n) * 4 * prod) / (20480 - prod);
        if (neg) q = -q;
        return q[15:0];
    endfunction

    function automatic t_result rotate_point(input t_point p);
        t_result r;
        logic signed [15:0] dx, dy, sx, cx, sy, cy;
        logic [7:0] ang;
        dx = p.point_x - cam_x_q;
        dy = p.point_y - cam_y_q;
        ang = 8'd0 - cam_facing_q;
        sx = bhaskara_sin(dx, ang);
        cx = bhaskara_sin(dx, ang + 8'd64);
        sy = bhaskara_sin(dy, ang);
        cy = bhaskara_sin(dy, ang + 8'd64);
        r.cam_c = cx - sy;
        r.cam_d = sx + cy;
        r.out_colour = p.point_colour;
        return r;
    endfunction

    // compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result actual=%h", $time, o_result);
                errors <= errors + 1;
            end else begin
                t_result e;
                e = pending_results.pop_front();
                if (e !== o_result) begin
                    $display("%0t mismatch expected c=%0d d=%0d col=%0d actual c=%0d d=%0d col=%0d",
                             $time, e.cam_c, e.cam_d, e.out_colour,
                             o_result.cam_c, o_result.cam_d, o_result.out_colour);
                    errors <= errors + 1;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_CAMERA_X:      cam_x_q = data;
            REG_CAMERA_Y:      cam_y_q = data;
            REG_CAMERA_FACING: cam_facing_q = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(input logic [15:0] x, input logic [15:0] y,
                              input logic [7:0] f);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        write_reg(REG_CAMERA_X, x);
        write_reg(REG_CAMERA_Y, y);
        write_reg(REG_CAMERA_FACING, {8'($urandom_range(255, 0)), f});
    endtask

    // one point beat, with an optional random gap before it
    task automatic send_point(input t_point p, input logic with_gap);
        int gap;
        if (with_gap) begin
            gap = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 5) : $urandom_range(2, 0);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start   <= 1'b1;
        i_point <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(rotate_point(p));
    endtask

    typedef struct {
        t_point  pt;
        logic    known;
        t_result res;
    } t_row;

    t_row directed[$];

    function automatic t_row mk(input logic [15:0] x, input logic [15:0] y,
                                input logic [7:0] c, input logic known,
                                input logic [15:0] rc, input logic [15:0] rd);
        t_row r;
        r.pt = '{x, y, c};
        r.known = known;
        r.res = '{rc, rd, c};
        return r;
    endfunction

    initial begin
        t_point p;
        int facings[6];
        t_result e;
        facings = '{0, 64, 128, 192, 1, 255};
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // at reset facing 0: cos term is n*1, sine term 0
        directed.push_back(mk(16'h0000, 16'h0000, 8'h00, 1, 16'h0000, 16'h0000));
        directed.push_back(mk(16'h7fff, 16'h0000, 8'hff, 1, 16'h7fff, 16'h0000));
        directed.push_back(mk(16'h8000, 16'h0000, 8'h55, 1, 16'h8000, 16'h0000));
        directed.push_back(mk(16'h0000, 16'h7fff, 8'haa, 1, 16'h0000, 16'h7fff));
        directed.push_back(mk(16'h0000, 16'h8000, 8'h01, 1, 16'h0000, 16'h8000));
        directed.push_back(mk(16'h7fff, 16'h7fff, 8'h80, 1, 16'h7fff, 16'h7fff));
        directed.push_back(mk(16'h8000, 16'h8000, 8'h7f, 1, 16'h8000, 16'h8000));
        directed.push_back(mk(16'h1234, 16'hfedc, 8'h3c, 0, '0, '0));
        foreach (directed[i]) begin
            send_point(directed[i].pt, 1'b0);
            if (directed[i].known) begin
                e = pending_results.pop_back();
                pending_results.push_back(directed[i].res);
            end
        end
        start <= 1'b0;

        // extreme settings: full-scale negated terms and sum overflow
        foreach (facings[k]) begin
            set_camera((k % 2) ? 16'h8000 : 16'h7fff, (k % 3) ? 16'h7fff : 16'h8000,
                       8'(facings[k]));
            send_point('{16'h8000, 16'h8000, 8'h00}, 1'b0);
            send_point('{16'h7fff, 16'h7fff, 8'hff}, 1'b0);
            send_point('{16'h0000, 16'h0000, 8'h5a}, 1'b0);
            start <= 1'b0;
        end
        // out-of-range index is ignored
        set_camera(16'h0000, 16'h0000, 8'd64);
        write_reg(2'd3, 16'hffff);
        send_point('{16'h4000, 16'hc000, 8'h11}, 1'b0);
        start <= 1'b0;

        // random points in phases of random camera settings
        for (int ph = 0; ph < 12; ph++) begin
            set_camera(16'($urandom), 16'($urandom), 8'($urandom));
            for (int i = 0; i < 100; i++) begin
                p.point_x = 16'($urandom);
                p.point_y = 16'($urandom);
                p.point_colour = 8'($urandom);
                send_point(p, ($urandom_range(3, 0) != 0) && (ph % 4 != 3));
            end
            start <= 1'b0;
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
